// ===== sv/bpa_pkg.sv =====
// Package: constants, types and state codes of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int PAGES  = 1024;
    localparam int ORDERS = 11;
    localparam int IDX_W  = $clog2(PAGES);
    localparam int LINK_W = IDX_W + 1;
    localparam int ORD_W  = 4;
    localparam int NUM_W  = 11;
    localparam int ST_W   = 2;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(1) << IDX_W;
    localparam logic [NUM_W-1:0]  NUM_RESET = NUM_W'(1024);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [ST_W-1:0] STAT_OK     = 2'd0;
    localparam logic [ST_W-1:0] STAT_NOMEM  = 2'd1;
    localparam logic [ST_W-1:0] STAT_BADORD = 2'd2;

    typedef struct packed {
        logic             alloc;
        logic [ORD_W-1:0] ord;
    } page_t;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } link_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_FCHK,
        ST_FTEST,
        ST_FBUD,
        ST_FMERGE,
        ST_U0,
        ST_U1,
        ST_U2,
        ST_U3,
        ST_P0,
        ST_P1,
        ST_SPLIT,
        ST_DONE
    } state_t;

endpackage

// ===== sv/buddy_page_allocator_core.sv =====
// Buddy page allocator core: request sequencer over page and link memories.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: action; tdata: order, block_index
//  m_axis    out  m_axis_tvalid/tready    tdata: alloc_index, status
//  cfg       in   cfg_valid/cfg_ready     cfg_data: num_pages
//
// One item at a time; a new item is accepted only in the idle state.
// Free: ends early when out of range or ignored, else merges with free buddies.
// Allocate: ends early on a bad order or out of memory, else splits the found block down.
// After reset a clearing pass over the PAGES (1024) pages marks every page allocated;
// no item is taken during it. The output register lets the next item enter while a
// result waits on m_axis_tready.
`timescale 1ns / 1ps
module buddy_page_allocator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,   // order[3:0], block_index[13:4]
    input  logic                      s_axis_tuser,   // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,   // alloc_index[9:0], status[11:10]
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bpa_pkg::NUM_W-1:0] cfg_data
);
    import bpa_pkg::*;

    state_t state_reg, state_next;

    logic              act_reg, act_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  bud_reg, bud_next;
    logic [ORD_W-1:0]  cur_o_reg, cur_o_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [LINK_W-1:0] p_reg, p_next;
    logic [IDX_W:0]    clr_reg, clr_next;
    logic [NUM_W-1:0]  num_pages_reg;
    logic [LINK_W-1:0] head_reg [ORDERS];
    logic [LINK_W-1:0] head_next [ORDERS];

    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [ST_W-1:0]   res_st_reg, res_st_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;
    logic [ST_W-1:0]   m_st_reg, m_st_next;

    logic              page_we;
    logic [IDX_W-1:0]  page_waddr, page_raddr;
    page_t             page_wdata, page_rdata;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr, link_raddr;
    link_t             link_wdata, link_rdata;

    logic              in_fire;
    logic              in_act;
    logic [ORD_W-1:0]  in_ord;
    logic [IDX_W-1:0]  in_idx;
    logic              found;
    logic [ORD_W-1:0]  t_found;
    logic [IDX_W-1:0]  bud_calc;
    logic [IDX_W-1:0]  push_addr;
    logic              top_order;
    logic              misaligned;
    logic              out_free;

    bpa_ram #(.WIDTH($bits(page_t)), .DEPTH(PAGES)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    bpa_ram #(.WIDTH($bits(link_t)), .DEPTH(PAGES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign in_act  = s_axis_tuser;
    assign in_ord  = s_axis_tdata[3:0];
    assign in_idx  = s_axis_tdata[13:4];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_st_reg, m_idx_reg};

    assign bud_calc   = idx_reg ^ (IDX_W'(1) << cur_o_reg);
    assign push_addr  = (act_reg == ACT_ALLOC) ? bud_reg : idx_reg;
    assign top_order  = (cur_o_reg == ORD_W'(ORDERS - 1));
    assign misaligned = |(idx_reg & ~({IDX_W{1'b1}} << page_rdata.ord));
    assign out_free   = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        found   = 1'b0;
        t_found = '0;
        for (int i = 0; i < ORDERS; i++)
        begin
            if (!found && ORD_W'(i) >= ord_reg && !head_reg[i][IDX_W])
            begin
                found   = 1'b1;
                t_found = ORD_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == (IDX_W + 1)'(PAGES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire)
                begin
                    if (in_act == ACT_FREE)
                        state_next = ({1'b0, in_idx} >= num_pages_reg) ? ST_DONE : ST_FCHK;
                    else
                        state_next = (in_ord >= ORD_W'(ORDERS)) ? ST_DONE : ST_SEARCH;
                end
            ST_SEARCH:
                state_next = found ? ST_U0 : ST_DONE;
            ST_FCHK:
                if (!page_rdata.alloc || page_rdata.ord >= ORD_W'(ORDERS) || misaligned)
                    state_next = ST_DONE;
                else
                    state_next = ST_FTEST;
            ST_FTEST:
                if (top_order || {1'b0, bud_calc} >= num_pages_reg)
                    state_next = ST_P0;
                else
                    state_next = ST_FBUD;
            ST_FBUD:
                state_next = (page_rdata.alloc || page_rdata.ord != cur_o_reg) ? ST_P0 : ST_U0;
            ST_FMERGE:
                state_next = ST_FTEST;
            ST_U0:
                state_next = ST_U1;
            ST_U1:
                state_next = ST_U2;
            ST_U2:
                state_next = ST_U3;
            ST_U3:
                state_next = (act_reg == ACT_ALLOC) ? ST_SPLIT : ST_FMERGE;
            ST_P0:
                if (!head_reg[cur_o_reg][IDX_W])
                    state_next = ST_P1;
                else
                    state_next = (act_reg == ACT_ALLOC) ? ST_SPLIT : ST_DONE;
            ST_P1:
                state_next = (act_reg == ACT_ALLOC) ? ST_SPLIT : ST_DONE;
            ST_SPLIT:
                state_next = (cur_o_reg > ord_reg) ? ST_P0 : ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        act_next     = act_reg;
        ord_next     = ord_reg;
        idx_next     = idx_reg;
        bud_next     = bud_reg;
        cur_o_next   = cur_o_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        clr_next     = clr_reg;
        res_idx_next = res_idx_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_st_next    = m_st_reg;
        head_next    = head_reg;

        page_we    = 1'b0;
        page_waddr = idx_reg;
        page_wdata = '{alloc: 1'b1, ord: '0};
        page_raddr = idx_reg;
        link_we    = 1'b0;
        link_waddr = idx_reg;
        link_wdata = '{next: NIL_LINK, prev: NIL_LINK};
        link_raddr = idx_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                page_we    = 1'b1;
                page_waddr = clr_reg[IDX_W-1:0];
                clr_next   = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                page_raddr = in_idx;
                if (in_fire)
                begin
                    act_next     = in_act;
                    ord_next     = in_ord;
                    idx_next     = in_idx;
                    res_idx_next = '0;
                    res_st_next  = STAT_OK;
                    if (in_act == ACT_ALLOC && in_ord >= ORD_W'(ORDERS))
                        res_st_next = STAT_BADORD;
                end
            end
            ST_SEARCH:
            begin
                if (found)
                begin
                    idx_next   = head_reg[t_found][IDX_W-1:0];
                    cur_o_next = t_found;
                end
                else
                begin
                    res_st_next = STAT_NOMEM;
                end
            end
            ST_FCHK:
                cur_o_next = page_rdata.ord;
            ST_FTEST:
            begin
                bud_next   = bud_calc;
                page_raddr = bud_calc;
            end
            ST_FBUD:
            begin
            end
            ST_FMERGE:
            begin
                idx_next   = idx_reg & bud_reg;
                cur_o_next = cur_o_reg + 1'b1;
                page_we    = 1'b1;
                page_waddr = idx_reg & bud_reg;
                page_wdata = '{alloc: 1'b1, ord: cur_o_reg + 1'b1};
            end
            ST_U0:
                link_raddr = (act_reg == ACT_ALLOC) ? idx_reg : bud_reg;
            ST_U1:
            begin
                n_next     = link_rdata.next;
                p_next     = link_rdata.prev;
                link_raddr = link_rdata.prev[IDX_W-1:0];
            end
            ST_U2:
            begin
                if (!p_reg[IDX_W])
                begin
                    link_we    = 1'b1;
                    link_waddr = p_reg[IDX_W-1:0];
                    link_wdata = '{next: n_reg, prev: link_rdata.prev};
                end
                else
                begin
                    head_next[cur_o_reg] = n_reg;
                end
                link_raddr = n_reg[IDX_W-1:0];
            end
            ST_U3:
            begin
                if (!n_reg[IDX_W])
                begin
                    link_we    = 1'b1;
                    link_waddr = n_reg[IDX_W-1:0];
                    link_wdata = '{next: link_rdata.next, prev: p_reg};
                end
            end
            ST_P0:
            begin
                n_next               = head_reg[cur_o_reg];
                link_we              = 1'b1;
                link_waddr           = push_addr;
                link_wdata           = '{next: head_reg[cur_o_reg], prev: NIL_LINK};
                link_raddr           = head_reg[cur_o_reg][IDX_W-1:0];
                head_next[cur_o_reg] = {1'b0, push_addr};
                page_we              = 1'b1;
                page_waddr           = push_addr;
                page_wdata           = '{alloc: 1'b0, ord: cur_o_reg};
            end
            ST_P1:
            begin
                link_we    = 1'b1;
                link_waddr = n_reg[IDX_W-1:0];
                link_wdata = '{next: link_rdata.next, prev: {1'b0, push_addr}};
            end
            ST_SPLIT:
            begin
                if (cur_o_reg > ord_reg)
                begin
                    cur_o_next = cur_o_reg - 1'b1;
                    bud_next   = idx_reg + (IDX_W'(1) << (cur_o_reg - 1'b1));
                end
                else
                begin
                    page_we      = 1'b1;
                    page_waddr   = idx_reg;
                    page_wdata   = '{alloc: 1'b1, ord: ord_reg};
                    res_idx_next = idx_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_st_next    = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
            num_pages_reg <= NUM_RESET;
            for (int i = 0; i < ORDERS; i++)
            begin
                head_reg[i] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            if (cfg_valid && cfg_ready)
            begin
                num_pages_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        ord_reg     <= ord_next;
        idx_reg     <= idx_next;
        bud_reg     <= bud_next;
        cur_o_reg   <= cur_o_next;
        n_reg       <= n_next;
        p_reg       <= p_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        m_idx_reg   <= m_idx_next;
        m_st_reg    <= m_st_next;
    end

endmodule

// ===== sv/bpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checker for the buddy page allocator core, bound to buddy_page_allocator_core.
`timescale 1ns / 1ps
module bpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import bpa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:10] == STAT_OK ||
                           m_axis_tdata[11:10] == STAT_NOMEM ||
                           m_axis_tdata[11:10] == STAT_BADORD))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11:10] != STAT_OK |-> m_axis_tdata[9:0] == '0)
        else $error("failed request returned an index");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
